### src/aspg_pkg.sv
package aspg_pkg;

   localparam int unsigned EDGE_W     = 16;
   localparam int unsigned STEPS_W    = 15;
   localparam int unsigned FILTER_W   = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TOTAL        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_MODE          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT_MODE         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT_EDGES        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_FILTER_TICKS = 3'd5;

   // Operation codes of an input item.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic [FILTER_W-1:0] FILTER_MAX = {FILTER_W{1'b1}};

   typedef struct packed {
      logic [STEPS_W-1:0]  step_total;
      logic                probe_mode;
      logic                run_mode;
      logic                exit_mode;
      logic [EDGE_W-1:0]   exit_edges;
      logic [FILTER_W-1:0] stop_filter_ticks;
   } cfg_type;

   typedef struct packed {
      logic operation;
      logic begin_stop_hit;
      logic end_stop_hit;
      logic tool_contact;
   } req_type;

   typedef struct packed {
      logic              step_level;
      logic              axis_on;
      logic              clock_running;
      logic              move_done;
      logic              stop_exited;
      logic [EDGE_W-1:0] edges_made;
   } rsp_type;

endpackage

### src/aspg_if.sv
interface aspg_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic begin_stop_hit;
   logic end_stop_hit;
   logic tool_contact;

   modport source (output valid, output operation, output begin_stop_hit,
                   output end_stop_hit, output tool_contact, input ready);
   modport sink   (input valid, input operation, input begin_stop_hit,
                   input end_stop_hit, input tool_contact, output ready);
endinterface

interface aspg_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       step_level;
   logic                       axis_on;
   logic                       clock_running;
   logic                       move_done;
   logic                       stop_exited;
   logic [aspg_pkg::EDGE_W-1:0] edges_made;

   modport source (output valid, output step_level, output axis_on, output clock_running,
                   output move_done, output stop_exited, output edges_made, input ready);
   modport sink   (input valid, input step_level, input axis_on, input clock_running,
                   input move_done, input stop_exited, input edges_made, output ready);
endinterface

### src/aspg_csr.sv
module aspg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [aspg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aspg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output aspg_pkg::cfg_type                  cfg
);

   aspg_pkg::cfg_type cfg_ff;
   aspg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            aspg_pkg::CSR_STEP_TOTAL:
               cfg_in.step_total = csr_wdata[aspg_pkg::STEPS_W-1:0];
            aspg_pkg::CSR_PROBE_MODE:        cfg_in.probe_mode = csr_wdata[0];
            aspg_pkg::CSR_RUN_MODE:          cfg_in.run_mode   = csr_wdata[0];
            aspg_pkg::CSR_EXIT_MODE:         cfg_in.exit_mode  = csr_wdata[0];
            aspg_pkg::CSR_EXIT_EDGES:
               cfg_in.exit_edges = csr_wdata[aspg_pkg::EDGE_W-1:0];
            aspg_pkg::CSR_STOP_FILTER_TICKS:
               cfg_in.stop_filter_ticks = csr_wdata[aspg_pkg::FILTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/aspg_core.sv
module aspg_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  aspg_pkg::req_type req_item,
   input  aspg_pkg::cfg_type cfg,
   output aspg_pkg::rsp_type rsp_next
);

   logic [aspg_pkg::EDGE_W-1:0]   edge_ff, edge_in;
   logic                          step_ff, step_in;
   logic                          axis_ff, axis_in;
   logic                          tick_ff, tick_in;
   logic                          done_ff, done_in;
   logic                          exited_ff, exited_in;
   logic [aspg_pkg::FILTER_W-1:0] filt_ff, filt_in;

   logic [aspg_pkg::EDGE_W-1:0]   edge_limit;
   logic                          any_stop;
   logic                          filtering;
   logic                          halt;

   assign edge_limit = {cfg.step_total, 1'b0};
   assign any_stop   = req_item.begin_stop_hit | req_item.end_stop_hit;
   assign filtering  = cfg.run_mode | cfg.probe_mode;

   always_comb begin
      edge_in   = edge_ff;
      step_in   = step_ff;
      axis_in   = axis_ff;
      tick_in   = tick_ff;
      done_in   = done_ff;
      exited_in = exited_ff;
      filt_in   = filt_ff;
      halt      = 1'b0;
      if (req_item.operation == aspg_pkg::OP_START) begin
         // A start clears the move counters but leaves the step line level alone.
         edge_in   = '0;
         filt_in   = '0;
         done_in   = 1'b0;
         exited_in = 1'b0;
         axis_in   = 1'b1;
         tick_in   = 1'b1;
      end else if (tick_ff) begin
         if (edge_ff < edge_limit) begin
            step_in = ~step_ff;
            edge_in = edge_ff + 1'b1;
         end else begin
            done_in = 1'b1;
            halt    = 1'b1;
         end
         if (!edge_in[0] && cfg.probe_mode && req_item.tool_contact) begin
            done_in = 1'b1;
            halt    = 1'b1;
         end
         if (cfg.exit_mode && edge_in == cfg.exit_edges) begin
            halt      = 1'b1;
            exited_in = 1'b1;
         end else if (any_stop && filtering) begin
            if (filt_ff != aspg_pkg::FILTER_MAX) begin
               filt_in = filt_ff + 1'b1;
            end
            if (filt_in >= cfg.stop_filter_ticks) begin
               halt = 1'b1;
            end
         end else if (filtering) begin
            filt_in = '0;
         end
         if (halt) begin
            axis_in = 1'b0;
            tick_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff   <= '0;
         step_ff   <= 1'b0;
         axis_ff   <= 1'b0;
         tick_ff   <= 1'b0;
         done_ff   <= 1'b0;
         exited_ff <= 1'b0;
         filt_ff   <= '0;
      end else if (take) begin
         edge_ff   <= edge_in;
         step_ff   <= step_in;
         axis_ff   <= axis_in;
         tick_ff   <= tick_in;
         done_ff   <= done_in;
         exited_ff <= exited_in;
         filt_ff   <= filt_in;
      end
   end

   always_comb begin
      rsp_next.step_level    = step_in;
      rsp_next.axis_on       = axis_in;
      rsp_next.clock_running = tick_in;
      rsp_next.move_done     = done_in;
      rsp_next.stop_exited   = exited_in;
      rsp_next.edges_made    = edge_in;
   end

   // The driver enable and the tick gate are always switched together.
   assert property (@(posedge clock) disable iff (reset) axis_ff == tick_ff)
      else $error("axis enable and tick gate disagree");

   // A tick that arrives while stopped leaves the step state untouched.
   assert property (@(posedge clock) disable iff (reset)
      (take && req_item.operation == aspg_pkg::OP_TICK && !tick_ff)
         |=> ($stable(edge_ff) && $stable(step_ff) && $stable(filt_ff)))
      else $error("tick changed state while stopped");

   // A start always leaves a fresh, running move behind it.
   assert property (@(posedge clock) disable iff (reset)
      (take && req_item.operation == aspg_pkg::OP_START)
         |=> (edge_ff == '0 && tick_ff && !done_ff && !exited_ff))
      else $error("start did not reset the move");

   // The exit flag is only raised together with a stop.
   assert property (@(posedge clock) disable iff (reset) $rose(exited_ff) |-> !tick_ff)
      else $error("exit flagged while still running");

endmodule

### src/aspg_rsp_stage.sv
module aspg_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  aspg_pkg::rsp_type item_in,
   output logic              space,
   aspg_rsp_if.source        rsp
);

   logic              valid_ff, valid_in;
   aspg_pkg::rsp_type item_ff;

   // The register can take a new item when empty or when its item leaves now.
   assign space    = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.step_level    = item_ff.step_level;
   assign rsp.axis_on       = item_ff.axis_on;
   assign rsp.clock_running = item_ff.clock_running;
   assign rsp.move_done     = item_ff.move_done;
   assign rsp.stop_exited   = item_ff.stop_exited;
   assign rsp.edges_made    = item_ff.edges_made;

endmodule

### src/axis_step_pulse_generator.sv
// A result item is registered and shown in the cycle after its item is accepted.
// Throughput: one item per cycle while the receiver holds ready high; the output
// register is refilled in the same cycle its item is taken.
// Reset: synchronous, active high; clears the move state, all configuration
// registers and the result valid flag. The step line starts low, the axis off.
module axis_step_pulse_generator (
   input  logic                            clock,
   input  logic                            reset,
   aspg_req_if.sink                        req_chan,
   aspg_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [aspg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aspg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   aspg_pkg::cfg_type cfg;
   aspg_pkg::req_type req_item;
   aspg_pkg::rsp_type rsp_next;
   logic              space;
   logic              take;

   // Configuration is held in its own register file and read by the core.
   aspg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   always_comb begin
      req_item.operation      = req_chan.operation;
      req_item.begin_stop_hit = req_chan.begin_stop_hit;
      req_item.end_stop_hit   = req_chan.end_stop_hit;
      req_item.tool_contact   = req_chan.tool_contact;
   end

   // An item is taken whenever the result register has room for its result.
   assign req_chan.ready = space;
   assign take           = req_chan.valid && space;

   // The core holds the axis state and works out the next state of each item
   // in one pass; the same values become the item's result.
   aspg_core u_core (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_item (req_item),
      .cfg      (cfg),
      .rsp_next (rsp_next)
   );

   aspg_rsp_stage u_rsp_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (take),
      .item_in (rsp_next),
      .space   (space),
      .rsp     (rsp_chan)
   );

endmodule

### tb/sv/axis_step_checker.sv
module axis_step_checker
   import aspg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   aspg_req_if                   req_mon,
   aspg_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);

   cfg_type             axis_cfg;
   logic [EDGE_W-1:0]   edge_count;
   logic                step_line;
   logic                axis_en;
   logic                tick_en;
   logic                done;
   logic                exited;
   logic [FILTER_W-1:0] filter_count;

   rsp_type pending_rsp_q[$];

   // Moves the axis state on by one accepted item and returns the item the
   // block must show for it.
   function automatic rsp_type advance_axis(req_type item);
      rsp_type          shown;
      logic             any_stop;
      logic             filtering;
      logic [EDGE_W-1:0] edge_limit;
      any_stop   = item.begin_stop_hit | item.end_stop_hit;
      filtering  = axis_cfg.run_mode | axis_cfg.probe_mode;
      edge_limit = {axis_cfg.step_total, 1'b0};
      if (item.operation == OP_START) begin
         edge_count   = '0;
         filter_count = '0;
         done         = 1'b0;
         exited       = 1'b0;
         axis_en      = 1'b1;
         tick_en      = 1'b1;
      end else if (tick_en) begin
         if (edge_count < edge_limit) begin
            step_line  = ~step_line;
            edge_count = edge_count + 1'b1;
         end else begin
            done    = 1'b1;
            axis_en = 1'b0;
            tick_en = 1'b0;
         end
         if (!edge_count[0] && axis_cfg.probe_mode && item.tool_contact) begin
            done    = 1'b1;
            axis_en = 1'b0;
            tick_en = 1'b0;
         end
         if (axis_cfg.exit_mode && edge_count == axis_cfg.exit_edges) begin
            axis_en = 1'b0;
            tick_en = 1'b0;
            exited  = 1'b1;
         end else if (any_stop && filtering) begin
            if (filter_count != FILTER_MAX)
               filter_count = filter_count + 1'b1;
            if (filter_count >= axis_cfg.stop_filter_ticks) begin
               axis_en = 1'b0;
               tick_en = 1'b0;
            end
         end else if (!any_stop && filtering) begin
            filter_count = '0;
         end
      end
      shown.step_level    = step_line;
      shown.axis_on       = axis_en;
      shown.clock_running = tick_en;
      shown.move_done     = done;
      shown.stop_exited   = exited;
      shown.edges_made    = edge_count;
      return shown;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      req_type item;
      if (reset) begin
         axis_cfg     = '0;
         edge_count   = '0;
         step_line    = 1'b0;
         axis_en      = 1'b0;
         tick_en      = 1'b0;
         done         = 1'b0;
         exited       = 1'b0;
         filter_count = '0;
         pending_rsp_q.delete();
         mismatches   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_rsp_q.size() == 0) begin
               $error("result item arrived with no item expected");
               mismatches++;
            end else begin
               want = pending_rsp_q.pop_front();
               check_field("step_level", 32'(want.step_level), 32'(rsp_mon.step_level));
               check_field("axis_on", 32'(want.axis_on), 32'(rsp_mon.axis_on));
               check_field("clock_running", 32'(want.clock_running),
                           32'(rsp_mon.clock_running));
               check_field("move_done", 32'(want.move_done), 32'(rsp_mon.move_done));
               check_field("stop_exited", 32'(want.stop_exited), 32'(rsp_mon.stop_exited));
               check_field("edges_made", 32'(want.edges_made), 32'(rsp_mon.edges_made));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            item.operation      = req_mon.operation;
            item.begin_stop_hit = req_mon.begin_stop_hit;
            item.end_stop_hit   = req_mon.end_stop_hit;
            item.tool_contact   = req_mon.tool_contact;
            pending_rsp_q.push_back(advance_axis(item));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_TOTAL:        axis_cfg.step_total        = csr_wdata[STEPS_W-1:0];
               CSR_PROBE_MODE:        axis_cfg.probe_mode        = csr_wdata[0];
               CSR_RUN_MODE:          axis_cfg.run_mode          = csr_wdata[0];
               CSR_EXIT_MODE:         axis_cfg.exit_mode         = csr_wdata[0];
               CSR_EXIT_EDGES:        axis_cfg.exit_edges        = csr_wdata[EDGE_W-1:0];
               CSR_STOP_FILTER_TICKS: axis_cfg.stop_filter_ticks = csr_wdata[FILTER_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = pending_rsp_q.size();
   end

endmodule

### tb/sv/axis_step_pulse_generator_test.sv
module axis_step_pulse_generator_test;
   import aspg_pkg::*;

   // The run is short; this limit is many times the slowest legal run.
   localparam int unsigned CYCLE_LIMIT = 300000;
   // Length of the long receiver stall that backs the block up.
   localparam int unsigned HOLD_CYCLES = 60;
   // Number of random input items to send after the directed part.
   localparam int unsigned RANDOM_ITEMS = 700;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    outstanding;

   // When set, neither side idles. When long_hold is set, the receiver
   // holds ready low for the long stall and then clears it.
   bit no_idle;
   bit long_hold;

   aspg_req_if req_chan ();
   aspg_rsp_if rsp_chan ();

   axis_step_pulse_generator uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   axis_step_checker axis_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every call of the tasks below starts and ends at a falling edge, at
   // which no input has been assigned yet. That keeps each input to a single
   // nonblocking update per time step.

   // Offers one item and returns at the falling edge after it was taken.
   // Random idle cycles hold valid low before the item goes out.
   task automatic send(logic op, logic begin_hit, logic end_hit, logic tool);
      while (!no_idle && $urandom_range(0, 99) < 14) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.operation      <= op;
      req_chan.begin_stop_hit <= begin_hit;
      req_chan.end_stop_hit   <= end_hit;
      req_chan.tool_contact   <= tool;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Lets the block drain every expected item, then writes all six
   // registers. Register writes are only made while the block is idle.
   task automatic program_axis(logic [STEPS_W-1:0] steps, logic probe, logic run,
                               logic exit_on, logic [EDGE_W-1:0] exit_at,
                               logic [FILTER_W-1:0] filter);
      logic [CSR_DATA_W-1:0] values [6];
      logic [CSR_IDX_W-1:0]  regs [6];
      values[0] = CSR_DATA_W'(steps);
      values[1] = CSR_DATA_W'(probe);
      values[2] = CSR_DATA_W'(run);
      values[3] = CSR_DATA_W'(exit_on);
      values[4] = CSR_DATA_W'(exit_at);
      values[5] = CSR_DATA_W'(filter);
      regs[0] = CSR_STEP_TOTAL;
      regs[1] = CSR_PROBE_MODE;
      regs[2] = CSR_RUN_MODE;
      regs[3] = CSR_EXIT_MODE;
      regs[4] = CSR_EXIT_EDGES;
      regs[5] = CSR_STOP_FILTER_TICKS;
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      // The result is registered in the cycle after its item, so the extra edge
      // below is plenty for the block to settle.
      @(negedge clock);
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= values[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // The receiver idles at random, except while no_idle is set, and once
   // stalls for a long stretch so that the block fills up and stops taking
   // input items.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= 14);
      end
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int                  sent;
      int                  phase;
      int                  count;
      int                  stop_pct;
      int                  tool_pct;
      int                  pick;
      logic [STEPS_W-1:0]  steps;
      logic [EDGE_W-1:0]   exit_at;
      logic [FILTER_W-1:0] filter;

      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_index               = '0;
      csr_wdata               = '0;
      req_chan.valid          = 1'b0;
      req_chan.operation      = OP_TICK;
      req_chan.begin_stop_hit = 1'b0;
      req_chan.end_stop_hit   = 1'b0;
      req_chan.tool_contact   = 1'b0;
      no_idle                 = 1'b0;
      long_hold               = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // A move of zero steps: the tick before the start is ignored, the
      // first tick after it finishes the move, and later ticks are ignored.
      program_axis('0, 1'b0, 1'b0, 1'b0, '0, '0);
      send(OP_TICK, 1'b0, 1'b0, 1'b0);
      send(OP_START, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b0, 1'b0, 1'b0);

      // Probing: a touch on an odd edge count is ignored, on an even one it
      // ends the move.
      program_axis(15'd2, 1'b1, 1'b0, 1'b0, '0, '0);
      send(OP_START, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b0, 1'b0, 1'b1);
      send(OP_TICK, 1'b0, 1'b0, 1'b1);
      send(OP_TICK, 1'b0, 1'b0, 1'b0);

      // The longest move with a filter of three: a free tick clears the
      // filter count, and three stop ticks in a row then halt the axis.
      program_axis('1, 1'b0, 1'b1, 1'b0, '0, 8'd3);
      send(OP_START, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b0, 1'b1, 1'b0);
      send(OP_TICK, 1'b1, 1'b1, 1'b0);
      send(OP_TICK, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b1, 1'b0, 1'b0);
      send(OP_TICK, 1'b1, 1'b0, 1'b0);
      send(OP_TICK, 1'b1, 1'b0, 1'b0);

      // Exit move: the exit stop wins over end-stop filtering on its tick.
      program_axis(15'd5, 1'b0, 1'b1, 1'b1, 16'd3, '0);
      send(OP_START, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b0, 1'b1, 1'b0);

      // Largest exit count and filter: neither stops a one-step move.
      program_axis(15'd1, 1'b1, 1'b1, 1'b0, '1, '1);
      send(OP_START, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b0, 1'b0, 1'b1);
      send(OP_TICK, 1'b0, 1'b1, 1'b0);
      send(OP_TICK, 1'b1, 1'b0, 1'b0);

      // With a filter of zero the first stop tick halts the axis.
      program_axis(15'd4, 1'b0, 1'b1, 1'b0, '0, '0);
      send(OP_START, 1'b0, 1'b0, 1'b0);
      send(OP_TICK, 1'b0, 1'b1, 1'b0);

      // Random phases. Most are well-formed moves: a start followed by
      // ticks, so the step counter gets deep into the move. The rest are
      // random items, starts and ticks alike. Sizes stay small so
      // that moves complete, with the largest values now and then.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         steps = (pick == 0) ? STEPS_W'($urandom_range(0, 32767)) :
                 (pick == 1) ? '1 : STEPS_W'($urandom_range(0, 15));
         pick = $urandom_range(0, 9);
         exit_at = (pick == 0) ? EDGE_W'($urandom_range(0, 65535)) :
                   (pick == 1) ? '1 : EDGE_W'($urandom_range(0, 34));
         pick = $urandom_range(0, 9);
         filter = (pick == 0) ? FILTER_W'($urandom_range(0, 255)) :
                  (pick == 1) ? '1 : FILTER_W'($urandom_range(0, 5));
         program_axis(steps, 1'($urandom), 1'($urandom), 1'($urandom), exit_at, filter);

         // A few phases run with no idle cycle on either side.
         no_idle = (phase >= 6 && phase < 10);
         // The sender keeps offering items through the long receiver stall.
         if (phase == 2)
            long_hold = 1'b1;

         count = (phase == 2) ? 40 : $urandom_range(5, 40);
         if ($urandom_range(0, 99) < 85) begin
            stop_pct = ($urandom_range(0, 3) == 0) ? 60 : 6;
            tool_pct = $urandom_range(0, 30);
            send(OP_START, 1'($urandom), 1'($urandom), 1'($urandom));
            for (int i = 0; i < count; i++)
               send(($urandom_range(0, 99) < 3) ? OP_START : OP_TICK,
                    $urandom_range(0, 99) < stop_pct,
                    $urandom_range(0, 99) < stop_pct,
                    $urandom_range(0, 99) < tool_pct);
            sent += count + 1;
         end else begin
            for (int i = 0; i < count; i++)
               send(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            sent += count;
         end
         phase++;
      end

      // Drain: wait for every expected item, then a few edges so that a
      // stray extra result would still be seen.
      req_chan.valid <= 1'b0;
      no_idle = 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
src/aspg_pkg.sv
src/aspg_if.sv
src/aspg_csr.sv
src/aspg_core.sv
src/aspg_rsp_stage.sv
src/axis_step_pulse_generator.sv
tb/sv/axis_step_checker.sv
tb/sv/axis_step_pulse_generator_test.sv
